[sv/desbe_pkg.sv]
// ----------------------------------------------------------------------------
// desbe_pkg
// Permutation tables, S-boxes and helper functions for the DES core.
// ----------------------------------------------------------------------------
package desbe_pkg;

  typedef logic [7:0] pos_t;

  localparam int unsigned NumRounds = 16;

  localparam pos_t IpTab [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

  localparam pos_t FpTab [64] = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25};

  localparam pos_t ETab [48] = '{
    8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
    8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

  localparam pos_t PTab [32] = '{
    8'd16, 8'd7, 8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5, 8'd18, 8'd31, 8'd10,
    8'd2,  8'd8, 8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6, 8'd22, 8'd11, 8'd4,  8'd25};

  localparam pos_t Pc1Tab [56] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

  localparam pos_t Pc2Tab [48] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

  // 1 = single-bit rotation in that round, else two
  localparam logic [15:0] RotOne = 16'b1000_0001_0000_0011;

  localparam logic [3:0] SBox [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12, 4'd5,
      4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1, 4'd10, 4'd6,
      4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2,
      4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0, 4'd15, 4'd12, 4'd8, 4'd2,
      4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13, 4'd12,
      4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14, 4'd12, 4'd0,
      4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13,
      4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15, 4'd13, 4'd8, 4'd10, 4'd1,
      4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7, 4'd11,
      4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10, 4'd2, 4'd8,
      4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3,
      4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7, 4'd1, 4'd10, 4'd13, 4'd0,
      4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5, 4'd11,
      4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3, 4'd4, 4'd7,
      4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7,
      4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4, 4'd3, 4'd15, 4'd0, 4'd6,
      4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15, 4'd13,
      4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1, 4'd5, 4'd0,
      4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7,
      4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14, 4'd11, 4'd8, 4'd12, 4'd7,
      4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4, 4'd14,
      4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5, 4'd6, 4'd1,
      4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12,
      4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6, 4'd4, 4'd3, 4'd2, 4'd12,
      4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7, 4'd5,
      4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10, 4'd14, 4'd3,
      4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7,
      4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2, 4'd6, 4'd11, 4'd13, 4'd8,
      4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14, 4'd5,
      4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4, 4'd12, 4'd5,
      4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14,
      4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8, 4'd2, 4'd1, 4'd14, 4'd7,
      4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] w);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = w[64-int'(IpTab[k])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] w);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = w[64-int'(FpTab[k])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] w);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) r[55-k] = w[64-int'(Pc1Tab[k])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] w);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = w[56-int'(Pc2Tab[k])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic one);
    return one ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
  endfunction

  // Feistel function: E, key mix, S-boxes, P
  function automatic logic [31:0] feistel(input logic [31:0] h, input logic [47:0] sk);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] r;
    for (int k = 0; k < 48; k++) x[47-k] = h[32-int'(ETab[k])];
    x = x ^ sk;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBox[b][{six[5], six[0], six[4:1]}];
    end
    for (int k = 0; k < 32; k++) r[31-k] = s[32-int'(PTab[k])];
    return r;
  endfunction

endpackage

[sv/desbe_round.sv]
// ----------------------------------------------------------------------------
// desbe_round
// One registered DES round: key schedule step plus Feistel step.
// ----------------------------------------------------------------------------
module desbe_round #(
  parameter logic RotOneBit = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [27:0] c_i,
  input  logic [27:0] d_i,
  input  logic [31:0] l_i,
  input  logic [31:0] r_i,
  output logic        valid_o,
  output logic [27:0] c_o,
  output logic [27:0] d_o,
  output logic [31:0] l_o,
  output logic [31:0] r_o
);

  logic        valid_q;
  logic [27:0] c_d, d_d, c_q, d_q;
  logic [31:0] l_q, r_q, r_d;

  always_comb begin
    c_d = desbe_pkg::rot28(c_i, RotOneBit);
    d_d = desbe_pkg::rot28(d_i, RotOneBit);
    r_d = l_i ^ desbe_pkg::feistel(r_i, desbe_pkg::perm_pc2({c_d, d_d}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    d_q <= d_d;
    l_q <= r_i;
    r_q <= r_d;
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;
  assign d_o     = d_q;
  assign l_o     = l_q;
  assign r_o     = r_q;

endmodule

[sv/des_block_encrypt_core.sv]
// ----------------------------------------------------------------------------
// des_block_encrypt_core
// Pipelined DES single-block encryption, one block per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive key_block_i and plaintext_block_i with start_i high; a beat is
//   taken on every edge where start is high and busy low. busy is
//   always low: the pipeline takes a new block every cycle.
//   Stages: input register (PC-1, IP), sixteen round registers (one
//   Feistel round and one key rotation each), output register (swap, FP).
//   done_o is high once the block has passed the input register, the
//   sixteen round registers and the output register; throughput is one
//   block per cycle, set by the one-round-per-stage pipeline.
//   ciphertext_block_o is valid for exactly the one cycle done_o is high;
//   the receiver cannot stall, so nothing backs up.
//   Reset clears all valid bits; blocks in flight are dropped.
// ----------------------------------------------------------------------------
module des_block_encrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key_block_i,
  input  logic [63:0] plaintext_block_i,
  output logic        done_o,
  output logic [63:0] ciphertext_block_o
);

  localparam int unsigned N = desbe_pkg::NumRounds;

  logic        in_valid_q;
  logic [55:0] cd_q;
  logic [63:0] ip_q;
  logic        out_valid_q;
  logic [63:0] ct_q;

  logic        v   [N+1];
  logic [27:0] c   [N+1];
  logic [27:0] d   [N+1];
  logic [31:0] l   [N+1];
  logic [31:0] r   [N+1];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    cd_q <= desbe_pkg::perm_pc1(key_block_i);
    ip_q <= desbe_pkg::perm_ip(plaintext_block_i);
    ct_q <= desbe_pkg::perm_fp({r[N], l[N]});
  end

  assign v[0] = in_valid_q;
  assign c[0] = cd_q[55:28];
  assign d[0] = cd_q[27:0];
  assign l[0] = ip_q[63:32];
  assign r[0] = ip_q[31:0];

  for (genvar g = 0; g < N; g++) begin : g_round
    desbe_round #(
      .RotOneBit(desbe_pkg::RotOne[g])
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[g]),
      .c_i    (c[g]),
      .d_i    (d[g]),
      .l_i    (l[g]),
      .r_i    (r[g]),
      .valid_o(v[g+1]),
      .c_o    (c[g+1]),
      .d_o    (d[g+1]),
      .l_o    (l[g+1]),
      .r_o    (r[g+1])
    );
  end

  assign done_o             = out_valid_q;
  assign ciphertext_block_o = ct_q;

endmodule
